### rtl/m3ua_data_tlv_parser_unit_macros.svh
// assertion macros shared by the rtl
`ifndef M3UA_DATA_TLV_PARSER_UNIT_MACROS_SVH
`define M3UA_DATA_TLV_PARSER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define M3UA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("m3ua parser assertion failed");

// next-cycle implication, checked out of reset
`define M3UA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("m3ua parser assertion failed");

`endif

### rtl/m3ua_tlv_pkg.sv
`default_nettype none
package m3ua_tlv_pkg;

  // protocol data parameter tag
  localparam logic [15:0] DATA_TAG = 16'h0210;
  // size of tag/length plus opc, dpc and routing bytes ahead of the payload
  localparam int unsigned DATA_HDR_BYTES = 16;
  localparam logic [7:0] SI_SCCP = 8'd3;
  localparam logic [7:0] HDR_ONE = 8'd1;

  // result status codes
  typedef enum logic [2:0] {
    ST_SCCP       = 3'd0,
    ST_NOT_SCCP   = 3'd1,
    ST_NO_DATA    = 3'd2,
    ST_BAD_HDR    = 3'd3,
    ST_SHORT_DATA = 3'd4,
    ST_MALFORMED  = 3'd5
  } status_t;

  // parse phase
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_SEARCH  = 2'd1,
    PH_CAPTURE = 2'd2,
    PH_DONE    = 2'd3
  } phase_t;

  // one result transaction
  typedef struct packed {
    status_t     status;
    logic [31:0] opc;
    logic [31:0] dpc;
    logic [7:0]  si;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;
  } result_t;

endpackage
`default_nettype wire

### rtl/m3ua_tlv_walker.sv
`default_nettype none
module m3ua_tlv_walker #(
  parameter int PosBits = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last,
  output m3ua_tlv_pkg::result_t  res
);
  import m3ua_tlv_pkg::*;

  localparam int NpsW = ((PosBits > 16) ? PosBits : 16) + 1;
  localparam int Cw   = NpsW + 1;
  localparam int Lw   = (Cw > 32) ? Cw : 32;

  logic [PosBits-1:0] pos_r, pos_nxt;
  phase_t             phase_r, phase_nxt;
  logic [31:0]        usable_r, usable_nxt;
  logic [NpsW-1:0]    nps_r, nps_nxt;
  logic [15:0]        plen_r, plen_nxt;
  logic [31:0]        shift_r, shift_nxt;
  logic [31:0]        opc_r, opc_nxt;
  logic [31:0]        dpc_r, dpc_nxt;
  logic [7:0]         si_r, si_nxt;
  status_t            fstat_r, fstat_nxt;

  // per-byte parse step
  always_comb begin
    logic [PosBits-1:0] pos_max;
    logic               pos_ok;
    logic               considered;
    logic [Cw-1:0]      pos_c;
    logic [Cw-1:0]      nps3;
    logic [Cw-1:0]      nps4;
    logic [Cw-1:0]      idx;
    logic [16:0]        rnd;
    logic [15:0]        tag;
    logic [15:0]        len;
    logic [Cw-1:0]      off;
    status_t            st;

    pos_max    = '1;
    pos_ok     = (pos_r != pos_max);
    considered = (Lw'(pos_r) < Lw'(usable_r)) && pos_ok;
    pos_c      = Cw'(pos_r);
    nps3       = Cw'(nps_r) + Cw'(3);
    nps4       = Cw'(nps_r) + Cw'(4);
    idx        = pos_c - nps4;
    rnd        = '0;
    tag        = '0;
    len        = '0;

    pos_nxt    = pos_r;
    phase_nxt  = phase_r;
    usable_nxt = usable_r;
    nps_nxt    = nps_r;
    plen_nxt   = plen_r;
    shift_nxt  = shift_r;
    opc_nxt    = opc_r;
    dpc_nxt    = dpc_r;
    si_nxt     = si_r;
    fstat_nxt  = fstat_r;

    unique case (phase_r)
      PH_HEADER: begin
        if ((pos_r == PosBits'(0) || pos_r == PosBits'(2) || pos_r == PosBits'(3))
            && data_byte != HDR_ONE) begin
          fstat_nxt = ST_BAD_HDR;
          phase_nxt = PH_DONE;
        end else begin
          if (pos_r >= PosBits'(4) && pos_r <= PosBits'(7)) begin
            shift_nxt = {shift_r[23:0], data_byte};
          end
          if (pos_r == PosBits'(7)) begin
            usable_nxt = shift_nxt;
            phase_nxt  = PH_SEARCH;
          end
        end
      end
      PH_SEARCH: begin
        if (pos_ok && pos_c >= Cw'(nps_r) && pos_c <= nps3) begin
          shift_nxt = {shift_r[23:0], data_byte};
        end
        if (pos_ok && pos_c == nps3) begin
          if (Lw'(nps4) < Lw'(usable_r) && !last) begin
            tag      = shift_nxt[31:16];
            len      = shift_nxt[15:0];
            plen_nxt = len;
            if (tag == DATA_TAG) begin
              if (len < 16'(DATA_HDR_BYTES)) begin
                fstat_nxt = ST_SHORT_DATA;
                phase_nxt = PH_DONE;
              end else begin
                phase_nxt = PH_CAPTURE;
              end
            end else if (len < 16'd4) begin
              fstat_nxt = ST_MALFORMED;
              phase_nxt = PH_DONE;
            end else begin
              rnd     = (17'(len) + 17'd3) & ~17'd3;
              nps_nxt = nps_r + NpsW'(rnd);
            end
          end else begin
            fstat_nxt = ST_NO_DATA;
            phase_nxt = PH_DONE;
          end
        end
      end
      PH_CAPTURE: begin
        if (!considered) begin
          fstat_nxt = ST_MALFORMED;
          phase_nxt = PH_DONE;
        end else if (idx < Cw'(4)) begin
          opc_nxt = {opc_r[23:0], data_byte};
        end else if (idx < Cw'(8)) begin
          dpc_nxt = {dpc_r[23:0], data_byte};
        end else begin
          si_nxt    = data_byte;
          fstat_nxt = (data_byte == SI_SCCP) ? ST_SCCP : ST_NOT_SCCP;
          phase_nxt = PH_DONE;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase

    // result as seen after this byte
    unique case (phase_nxt)
      PH_HEADER:  st = ST_BAD_HDR;
      PH_SEARCH:  st = ST_NO_DATA;
      PH_CAPTURE: st = ST_MALFORMED;
      default:    st = fstat_nxt;
    endcase
    off = Cw'(nps_nxt) + Cw'(DATA_HDR_BYTES);

    res.status         = st;
    res.opc            = (st == ST_SCCP || st == ST_NOT_SCCP) ? opc_nxt : '0;
    res.dpc            = (st == ST_SCCP || st == ST_NOT_SCCP) ? dpc_nxt : '0;
    res.si             = (st == ST_SCCP || st == ST_NOT_SCCP) ? si_nxt : '0;
    res.payload_offset = (st == ST_SCCP) ? off[15:0] : '0;
    res.payload_length = (st == ST_SCCP) ? (plen_nxt - 16'(DATA_HDR_BYTES)) : '0;

    // position advance, or back to start after the last byte
    if (!last) begin
      if (pos_ok) begin
        pos_nxt = pos_r + PosBits'(1);
      end
    end else begin
      pos_nxt    = '0;
      phase_nxt  = PH_HEADER;
      usable_nxt = '1;
      nps_nxt    = NpsW'(8);
      plen_nxt   = '0;
      shift_nxt  = '0;
      opc_nxt    = '0;
      dpc_nxt    = '0;
      si_nxt     = '0;
      fstat_nxt  = ST_NO_DATA;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      phase_r  <= PH_HEADER;
      usable_r <= '1;
      nps_r    <= NpsW'(8);
      plen_r   <= '0;
      shift_r  <= '0;
      opc_r    <= '0;
      dpc_r    <= '0;
      si_r     <= '0;
      fstat_r  <= ST_NO_DATA;
    end else if (step) begin
      pos_r    <= pos_nxt;
      phase_r  <= phase_nxt;
      usable_r <= usable_nxt;
      nps_r    <= nps_nxt;
      plen_r   <= plen_nxt;
      shift_r  <= shift_nxt;
      opc_r    <= opc_nxt;
      dpc_r    <= dpc_nxt;
      si_r     <= si_nxt;
      fstat_r  <= fstat_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/m3ua_data_tlv_parser_unit.sv
// latency: a result leaves after the last byte of a message is accepted, through
//   the input register, then the result register
// throughput: one message byte per cycle, except while a final byte waits on a stalled result
// a waiting result does not block bytes that carry no result
// reset: synchronous active-low rst_n clears valids and parse state to message start
`default_nettype none
`include "m3ua_data_tlv_parser_unit_macros.svh"
module m3ua_data_tlv_parser_unit #(
  parameter int POSITION_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [31:0]      out_origin_point_code,
  output logic [31:0]      out_destination_point_code,
  output logic [7:0]       out_service_indicator,
  output logic [15:0]      out_payload_offset,
  output logic [15:0]      out_payload_length
);
  import m3ua_tlv_pkg::*;

  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic        s1_go;
  logic        in_take;
  result_t     step_res;
  result_t     res_r;
  logic        out_valid_r, out_valid_nxt;

  // input stage: a byte without a result never waits on the output side
  assign s1_go    = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last;
    end
  end

  // parse step
  m3ua_tlv_walker #(
    .PosBits (POSITION_BITS)
  ) u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_go),
    .data_byte (s1_byte_r),
    .last      (s1_last_r),
    .res       (step_res)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      res_r <= step_res;
    end
  end

  assign out_valid                  = out_valid_r;
  assign out_status                 = res_r.status;
  assign out_origin_point_code      = res_r.opc;
  assign out_destination_point_code = res_r.dpc;
  assign out_service_indicator      = res_r.si;
  assign out_payload_offset         = res_r.payload_offset;
  assign out_payload_length         = res_r.payload_length;

  // a final byte never overwrites a result that is still held
  `M3UA_ASSERT_NOW(a_no_overwrite, clk, rst_n,
    s1_valid_r && s1_last_r && out_valid_r && out_stall, in_stall && !s1_go)
  // payload fields only for a found sccp payload
  `M3UA_ASSERT_NOW(a_payload_only_sccp, clk, rst_n,
    out_valid && out_status != ST_SCCP, out_payload_offset == 16'd0 && out_payload_length == 16'd0)
  // point codes only when a data parameter was fully captured
  `M3UA_ASSERT_NOW(a_codes_only_data, clk, rst_n,
    out_valid && out_status != ST_SCCP && out_status != ST_NOT_SCCP,
    out_origin_point_code == 32'd0 && out_destination_point_code == 32'd0
    && out_service_indicator == 8'd0)
  // sccp status agrees with the service indicator
  `M3UA_ASSERT_NOW(a_sccp_si, clk, rst_n,
    out_valid && out_status == ST_SCCP, out_service_indicator == SI_SCCP)
  // a result appears only after a final byte went through the parse step
  `M3UA_ASSERT_NEXT(a_result_source, clk, rst_n,
    !out_valid_r && !(s1_go && s1_last_r), !out_valid)

endmodule
`default_nettype wire
